FILE: sv/wvsd_pkg.sv
package wvsd_pkg;

  localparam int WINDOW_LEN = 20;
  localparam int SLOT_W     = $clog2(WINDOW_LEN);
  localparam int SAMPLE_W   = 16;
  localparam int THR_W      = 15;
  localparam int SQR_W      = 31;
  localparam int SUM_W      = SAMPLE_W + SLOT_W;
  localparam int SQSUM_W    = SQR_W + SLOT_W;
  localparam int VAR_W      = 2 * SUM_W;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [SLOT_W:0]     NWIN      = (SLOT_W + 1)'(WINDOW_LEN);
  localparam logic [2*SLOT_W:0]   NWIN_SQ   = (2 * SLOT_W + 1)'(WINDOW_LEN * WINDOW_LEN);
  localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

  localparam logic [PADDR_W-1:2] REG_STILL_THRESHOLD = '0;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET     = THR_W'(328);

  typedef struct packed {
    logic              adv;
    logic              acc;
    logic              upd;
    logic              wrapped;
    logic [SLOT_W-1:0] slot;
  } lane_ctl_t;

endpackage

FILE: sv/wvsd_if.sv
interface accel_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wvsd_pkg::SAMPLE_W-1:0] accel_x;
  logic signed [wvsd_pkg::SAMPLE_W-1:0] accel_y;
  logic signed [wvsd_pkg::SAMPLE_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface still_if;
  logic valid;
  logic ready;
  logic still;

  modport source (output valid, output still, input ready);
  modport sink (input valid, input still, output ready);
endinterface

FILE: sv/windowed_variance_stillness_detector.sv
// channel   dir  transaction payload
// -------   ---  -------------------------------
// sample    in   accel_x, accel_y, accel_z (s16)
// result    out  still (1 bit)
// apb       in   still_threshold at byte 0 (15 bits)
//
// One sample per cycle while result is not stalled; still is registered at the end of the pipeline.
// Three axis lanes each keep a window RAM (one read, one write per cycle) and
// running sums; the merge stage ANDs the lane compares into the output register.
// Reset clears sums, slot pointer and valids; window RAM needs no clearing pass.
// A stalled result freezes the whole pipeline, so sample.ready follows result.ready.
module windowed_variance_stillness_detector (
  input  logic                          clk,
  input  logic                          rst,
  accel_if.sink                         sample,
  still_if.source                       result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wvsd_pkg::PADDR_W-1:0]  paddr,
  input  logic [wvsd_pkg::PDATA_W-1:0]  pwdata,
  output logic [wvsd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic signed [wvsd_pkg::VAR_W-1:0] limit;
  wvsd_pkg::lane_ctl_t               ctl;
  logic [wvsd_pkg::SLOT_W-1:0]       slot;
  logic                              wrapped;
  logic [4:0]                        vld;
  logic                              adv;
  logic                              still_x;
  logic                              still_y;
  logic                              still_z;

  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;
  assign ctl.adv      = adv;
  assign ctl.acc      = adv && sample.valid;
  assign ctl.upd      = adv && vld[1];
  assign ctl.wrapped  = wrapped;
  assign ctl.slot     = slot;

  wvsd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  wvsd_lane u_lane_x (
    .clk        (clk),
    .ctl        (ctl),
    .sample     (sample.accel_x),
    .limit      (limit),
    .rst        (rst),
    .lane_still (still_x)
  );

  wvsd_lane u_lane_y (
    .clk        (clk),
    .ctl        (ctl),
    .sample     (sample.accel_y),
    .limit      (limit),
    .rst        (rst),
    .lane_still (still_y)
  );

  wvsd_lane u_lane_z (
    .clk        (clk),
    .ctl        (ctl),
    .sample     (sample.accel_z),
    .limit      (limit),
    .rst        (rst),
    .lane_still (still_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      wrapped <= 1'b0;
    end else if (ctl.acc) begin
      if (slot == wvsd_pkg::SLOT_LAST) begin
        slot    <= '0;
        wrapped <= 1'b1;
      end else begin
        slot <= slot + wvsd_pkg::SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result.valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[3:0], sample.valid};
      result.valid <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.still <= still_x && still_y && still_z;
    end
  end

endmodule

FILE: sv/wvsd_cfg.sv
module wvsd_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wvsd_pkg::PADDR_W-1:0]      paddr,
  input  logic [wvsd_pkg::PDATA_W-1:0]      pwdata,
  output logic [wvsd_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  output logic signed [wvsd_pkg::VAR_W-1:0] limit
);

  logic [wvsd_pkg::THR_W-1:0]   still_threshold;
  logic [2*wvsd_pkg::THR_W-1:0] thr_sq;
  logic                         hit;

  assign pready = 1'b1;
  assign hit    = (paddr[wvsd_pkg::PADDR_W-1:2] == wvsd_pkg::REG_STILL_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      still_threshold <= wvsd_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && hit) begin
      still_threshold <= pwdata[wvsd_pkg::THR_W-1:0];
    end
  end

  // limit = thr^2 * N^2, registered through thr_sq and then limit after a write
  always_ff @(posedge clk) begin
    thr_sq <= (2 * wvsd_pkg::THR_W)'(still_threshold) *
              (2 * wvsd_pkg::THR_W)'(still_threshold);
    limit  <= wvsd_pkg::VAR_W'(thr_sq) * wvsd_pkg::VAR_W'(wvsd_pkg::NWIN_SQ);
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = wvsd_pkg::PDATA_W'(still_threshold);
    end
  end

endmodule

FILE: sv/wvsd_lane.sv
module wvsd_lane (
  input  logic                                 clk,
  input  wvsd_pkg::lane_ctl_t                  ctl,
  input  logic signed [wvsd_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [wvsd_pkg::VAR_W-1:0]    limit,
  input  logic                                 rst,
  output logic                                 lane_still
);

  logic signed [wvsd_pkg::SAMPLE_W-1:0] mem [wvsd_pkg::WINDOW_LEN];
  logic signed [wvsd_pkg::SAMPLE_W-1:0] old_raw;
  logic signed [wvsd_pkg::SAMPLE_W-1:0] new_s0;
  logic                                 wrap_s0;
  logic signed [wvsd_pkg::SAMPLE_W-1:0] old_s0;
  logic signed [wvsd_pkg::SAMPLE_W-1:0] new_s1;
  logic signed [wvsd_pkg::SAMPLE_W-1:0] old_s1;
  logic [wvsd_pkg::SQR_W-1:0]           new_sq;
  logic [wvsd_pkg::SQR_W-1:0]           old_sq;
  logic signed [wvsd_pkg::SUM_W-1:0]    sum;
  logic [wvsd_pkg::SQSUM_W-1:0]         sqsum;
  logic signed [wvsd_pkg::VAR_W-1:0]    sum_sq;
  logic signed [wvsd_pkg::VAR_W-1:0]    n_sqsum;
  logic signed [wvsd_pkg::VAR_W-1:0]    spread;
  logic signed [2*wvsd_pkg::SAMPLE_W-1:0] new_prod;
  logic signed [2*wvsd_pkg::SAMPLE_W-1:0] old_prod;

  // slots not yet written since reset read as zero
  assign old_s0   = wrap_s0 ? old_raw : '0;
  assign new_prod = (2 * wvsd_pkg::SAMPLE_W)'(new_s0) * (2 * wvsd_pkg::SAMPLE_W)'(new_s0);
  assign old_prod = (2 * wvsd_pkg::SAMPLE_W)'(old_s0) * (2 * wvsd_pkg::SAMPLE_W)'(old_s0);
  assign spread   = n_sqsum - sum_sq;

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      mem[ctl.slot] <= sample;
    end
    if (ctl.adv) begin
      old_raw <= mem[ctl.slot];
      new_s0  <= sample;
      wrap_s0 <= ctl.wrapped;
      new_s1  <= new_s0;
      old_s1  <= old_s0;
      new_sq  <= new_prod[wvsd_pkg::SQR_W-1:0];
      old_sq  <= old_prod[wvsd_pkg::SQR_W-1:0];
      sum_sq  <= wvsd_pkg::VAR_W'(sum) * wvsd_pkg::VAR_W'(sum);
      n_sqsum <= wvsd_pkg::VAR_W'(sqsum) * wvsd_pkg::VAR_W'(wvsd_pkg::NWIN);
      lane_still <= (spread < limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      sqsum <= '0;
    end else if (ctl.upd) begin
      sum   <= sum + wvsd_pkg::SUM_W'(new_s1) - wvsd_pkg::SUM_W'(old_s1);
      sqsum <= sqsum + wvsd_pkg::SQSUM_W'(new_sq) - wvsd_pkg::SQSUM_W'(old_sq);
    end
  end

endmodule

FILE: dv/stillness_checker.sv
module stillness_checker (
  input  logic                         clk,
  input  logic                         rst,
  accel_if                             sample,
  still_if                             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [wvsd_pkg::PADDR_W-1:0] paddr,
  input  logic [wvsd_pkg::PDATA_W-1:0] pwdata,
  output int                           errors,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wvsd_pkg::*;

  logic signed [SAMPLE_W-1:0] window_hist [3][WINDOW_LEN];
  int                         next_slot;
  logic [THR_W-1:0]           threshold;
  logic                       still_queue [$];
  int                         fail_count = 0;

  // N * sum(x^2) - (sum x)^2 over one axis window
  function automatic longint axis_spread(input int axis);
    longint acc_sum;
    longint acc_sq;
    longint v;
    acc_sum = 0;
    acc_sq  = 0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      v = window_hist[axis][i];
      acc_sum += v;
      acc_sq  += v * v;
    end
    return longint'(WINDOW_LEN) * acc_sq - acc_sum * acc_sum;
  endfunction

  always @(posedge clk) begin
    logic   still_exp;
    longint limit;
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
          window_hist[a][i] = '0;
        end
      end
      next_slot = 0;
      threshold = THRESHOLD_RESET;
      still_queue.delete();
      pending <= 0;
      errors  <= fail_count;
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_STILL_THRESHOLD) begin
        threshold = pwdata[THR_W-1:0];
      end
      if (result.valid && result.ready) begin
        if (still_queue.size() == 0) begin
          $error("still: unexpected transaction, got %0b", result.still);
          fail_count++;
        end else begin
          still_exp = still_queue.pop_front();
          if (result.still !== still_exp) begin
            $error("still: expected %0b, got %0b", still_exp, result.still);
            fail_count++;
          end
        end
      end
      if (sample.valid && sample.ready) begin
        window_hist[0][next_slot] = sample.accel_x;
        window_hist[1][next_slot] = sample.accel_y;
        window_hist[2][next_slot] = sample.accel_z;
        next_slot = (next_slot == WINDOW_LEN - 1) ? 0 : next_slot + 1;
        limit = threshold;
        limit = limit * limit * WINDOW_LEN * WINDOW_LEN;
        still_queue.push_back(axis_spread(0) < limit && axis_spread(1) < limit &&
                              axis_spread(2) < limit);
      end
      pending <= still_queue.size();
      errors  <= fail_count;
    end
  end

endmodule

FILE: dv/tb_windowed_variance_stillness_detector.sv
module tb_windowed_variance_stillness_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import wvsd_pkg::*;

  localparam int                 CYCLE_LIMIT    = 100000;
  localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = {REG_STILL_THRESHOLD, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED  = ADDR_THRESHOLD + PADDR_W'(4);

  typedef enum logic [1:0] {SEG_QUIET, SEG_FLAT, SEG_WILD} seg_kind_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  logic [THR_W-1:0]   cur_thr;
  bit                 send_calm = 1'b0;

  accel_if sample_ch ();
  still_if result_ch ();

  windowed_variance_stillness_detector i_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  stillness_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_windowed_variance_stillness_detector: FAIL");
      $finish;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                             input logic [SAMPLE_W-1:0] z);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.accel_x <= x;
    sample_ch.accel_y <= y;
    sample_ch.accel_z <= z;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_threshold(input logic [PDATA_W-1:0] data);
    settle();
    reg_write(ADDR_THRESHOLD, data);
    cur_thr = data[THR_W-1:0];
  endtask

  function automatic logic [SAMPLE_W-1:0] jitter(input int base, input int amp);
    int v;
    v = base + int'($urandom_range(0, 2 * amp)) - amp;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  // segments of quiet noise around a random offset, flat runs and wild motion
  task automatic send_random(input int count);
    int                  seg_left;
    int                  pick;
    seg_kind_t           kind;
    int                  base [3];
    int                  amp [3];
    logic [SAMPLE_W-1:0] s [3];
    seg_left = 0;
    kind     = SEG_QUIET;
    for (int n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 60);
        pick     = $urandom_range(0, 9);
        kind     = (pick < 7) ? SEG_QUIET : (pick == 7) ? SEG_FLAT : SEG_WILD;
        for (int a = 0; a < 3; a++) begin
          base[a] = int'($urandom_range(0, 65535)) - 32768;
          amp[a]  = (int'(cur_thr) * int'($urandom_range(0, 8))) / 4 + $urandom_range(0, 1);
        end
      end
      for (int a = 0; a < 3; a++) begin
        case (kind)
          SEG_QUIET: s[a] = jitter(base[a], amp[a]);
          SEG_FLAT:  s[a] = jitter(base[a], 0);
          default:   s[a] = SAMPLE_W'($urandom_range(0, 65535));
        endcase
      end
      send_sample(s[0], s[1], s[2]);
      seg_left--;
    end
  endtask

  initial begin
    int stall;
    bit calm;
    calm = 1'b0;
    result_ch.ready <= 1'b0;
    repeat (7) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin
    logic [THR_W-1:0] thr;
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.accel_x <= '0;
    sample_ch.accel_y <= '0;
    sample_ch.accel_z <= '0;
    cur_thr = THRESHOLD_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset threshold; four equal samples over a zero window land exactly on the limit
    repeat (4) send_sample(16'd820, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h8000, 16'h0000);
    send_sample(16'h8000, 16'h7FFF, 16'hFFFF);
    send_sample(16'h5555, 16'hAAAA, 16'h0001);

    // zero threshold never reports still
    set_threshold('0);
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_random(70);

    set_threshold(PDATA_W'(32767));
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF, 16'h8000);
    send_random(70);

    // unmapped register is ignored, upper data bits are dropped
    settle();
    reg_write(ADDR_UNMAPPED, PDATA_W'(5));
    set_threshold(32'hFFFF_8001);
    send_random(70);

    repeat (5) begin
      thr = THR_W'($urandom_range(0, 32767) >> $urandom_range(0, 14));
      set_threshold({PDATA_W'($urandom_range(0, 131071)) << THR_W} | PDATA_W'(thr));
      send_random(75);
    end

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_windowed_variance_stillness_detector: PASS");
    end else begin
      $display("tb_windowed_variance_stillness_detector: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/wvsd_pkg.sv
sv/wvsd_if.sv
sv/wvsd_cfg.sv
sv/wvsd_lane.sv
sv/windowed_variance_stillness_detector.sv
dv/stillness_checker.sv
dv/tb_windowed_variance_stillness_detector.sv
